// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the project (htd_checker.sv).
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/htd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// htd_pkg
// Types and constants of the Huffman tree decoder.
// ---------------------------------------------------------------------------
package htd_pkg;

  localparam int ADDR_W    = 9;
  localparam int SYM_W     = 8;
  localparam int OPC_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 9;
  localparam int NODES_DEF = 512;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_BIT     = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT    = 1'b0,
    CFG_PRESENT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT_CUR,
    ST_CHILD
  } state_t;

  localparam logic OUTCOME_OK  = 1'b0;
  localparam logic OUTCOME_ERR = 1'b1;

  typedef struct packed {
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [ADDR_W-1:0] lchild;
    logic              lvalid;
    logic [ADDR_W-1:0] rchild;
    logic              rvalid;
  } node_t;

endpackage
`default_nettype wire

// ===== src/huffman_tree_decoder_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// huffman_tree_decoder_unit
// Bit-serial Huffman decoder walking a code tree held in node memory.
// ---------------------------------------------------------------------------
// Using the block: present an item with start while busy is low; it is taken
// at that clock edge. A node write, a restart, an unused opcode, or a code
// bit while no tree is present completes on acceptance and busy stays low.
// A code bit with a tree present walks in steps: the accept cycle issues
// reads of the root and cursor nodes, ST_ROOT_CUR evaluates them and reads
// the selected child, and ST_CHILD evaluates the child. When the root is a
// leaf or the chosen child is missing the bit finishes in ST_ROOT_CUR. These
// steps come from the synchronous read of node memory, since every bit needs
// the node the previous bit chose. A result is shown for exactly one cycle
// with out_valid high; the receiver cannot hold it off, so sample it in that
// cycle. Configuration is taken at any time on cfg_valid (cfg_ready is always
// high) but is meant to be written while idle; a new root is loaded into the
// cursor at the next restart, leaf or error.
// ---------------------------------------------------------------------------
module huffman_tree_decoder_unit #(
  parameter int NODES = htd_pkg::NODES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input words
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [htd_pkg::OPC_W-1:0]    in_opcode,
  input  wire logic [htd_pkg::ADDR_W-1:0]   in_node_index,
  input  wire logic                         in_node_leaf,
  input  wire logic [htd_pkg::SYM_W-1:0]    in_node_symbol,
  input  wire logic [htd_pkg::ADDR_W-1:0]   in_left_child,
  input  wire logic                         in_left_valid,
  input  wire logic [htd_pkg::ADDR_W-1:0]   in_right_child,
  input  wire logic                         in_right_valid,
  input  wire logic                         in_code_bit,
  // result words
  output      logic                         out_valid,
  output      logic [htd_pkg::SYM_W-1:0]    out_symbol,
  output      logic                         out_outcome,
  // configuration words
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [htd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [htd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import htd_pkg::*;

  // Memory index width, and a width that holds both an address and an index.
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EW = (AW > ADDR_W) ? AW : ADDR_W;

  function automatic logic [AW-1:0] to_idx(input logic [ADDR_W-1:0] a);
    logic [EW-1:0] e;
    e = EW'(a);
    return e[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [ADDR_W-1:0] a);
    return 32'(a) < 32'(NODES);
  endfunction

  // Control and configuration registers
  state_t            state_r,   state_nxt;
  logic [ADDR_W-1:0] cursor_r,  cursor_nxt;
  logic [ADDR_W-1:0] root_r,    root_nxt;
  logic              present_r, present_nxt;
  logic              bit_r,     bit_nxt;
  logic              ovalid_r,  ovalid_nxt;
  logic [SYM_W-1:0]  osym_r,    osym_nxt;
  logic              oout_r,    oout_nxt;

  // Node memory: two copies written together, so root and cursor read at once
  node_t             mem_a [NODES];
  node_t             mem_b [NODES];
  node_t             rd_a_r, rd_b_r;
  logic              ok_a_r, ok_b_r;
  logic [ADDR_W-1:0] addr_b;
  logic              wr_en;
  node_t             wr_node;

  logic              accept;
  node_t             root_node, cur_node, child_node;
  logic              child_present;
  logic [ADDR_W-1:0] child_addr;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid   = ovalid_r;
  assign out_symbol  = osym_r;
  assign out_outcome = oout_r;

  assign wr_en = accept && (in_opcode == OP_WRITE) && in_range(in_node_index);
  assign wr_node = '{leaf: in_node_leaf, sym: in_node_symbol,
                     lchild: in_left_child, lvalid: in_left_valid,
                     rchild: in_right_child, rvalid: in_right_valid};

  // Out-of-range nodes read as blank: no leaf, no children
  assign root_node  = ok_a_r ? rd_a_r : '0;
  assign cur_node   = ok_b_r ? rd_b_r : '0;
  assign child_node = ok_b_r ? rd_b_r : '0;

  assign child_present = bit_r ? cur_node.rvalid : cur_node.lvalid;
  assign child_addr    = bit_r ? cur_node.rchild : cur_node.lchild;

  // Port b reads the cursor on accept and the chosen child afterwards
  assign addr_b = (state_r == ST_ROOT_CUR) ? child_addr : cursor_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[to_idx(in_node_index)] <= wr_node;
      mem_b[to_idx(in_node_index)] <= wr_node;
    end
    rd_a_r <= mem_a[to_idx(root_r)];
    rd_b_r <= mem_b[to_idx(addr_b)];
    ok_a_r <= in_range(root_r);
    ok_b_r <= in_range(addr_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cursor_r  <= '0;
      root_r    <= '0;
      present_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cursor_r  <= cursor_nxt;
      root_r    <= root_nxt;
      present_r <= present_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r  <= bit_nxt;
    osym_r <= osym_nxt;
    oout_r <= oout_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    root_nxt    = root_r;
    present_nxt = present_r;
    bit_nxt     = bit_r;
    ovalid_nxt  = 1'b0;
    osym_nxt    = osym_r;
    oout_nxt    = oout_r;

    // Configuration writes
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ROOT:    root_nxt    = cfg_data[ADDR_W-1:0];
        CFG_PRESENT: present_nxt = cfg_data[0];
        default:     ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(in_opcode))
            OP_RESTART: cursor_nxt = root_r;
            OP_BIT: begin
              // drop bits while no tree is present
              if (present_r) begin
                bit_nxt   = in_code_bit;
                state_nxt = ST_ROOT_CUR;
              end
            end
            OP_WRITE: ;
            default:  ;
          endcase
        end
      end
      ST_ROOT_CUR: begin
        if (root_node.leaf) begin
          // single-leaf tree: every bit gives the root symbol, cursor holds
          ovalid_nxt = 1'b1;
          osym_nxt   = root_node.sym;
          oout_nxt   = OUTCOME_OK;
          state_nxt  = ST_IDLE;
        end else if (!child_present) begin
          ovalid_nxt = 1'b1;
          osym_nxt   = '0;
          oout_nxt   = OUTCOME_ERR;
          cursor_nxt = root_r;
          state_nxt  = ST_IDLE;
        end else begin
          cursor_nxt = child_addr;
          state_nxt  = ST_CHILD;
        end
      end
      ST_CHILD: begin
        // leaf emits and returns to root, otherwise advance to the child
        if (child_node.leaf) begin
          ovalid_nxt = 1'b1;
          osym_nxt   = child_node.sym;
          oout_nxt   = OUTCOME_OK;
          cursor_nxt = root_r;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/htd_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// htd_checker
// Port-level checks of the Huffman tree decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module htd_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [htd_pkg::OPC_W-1:0]  in_opcode,
  input wire logic                       out_valid,
  input wire logic [htd_pkg::SYM_W-1:0]  out_symbol,
  input wire logic                       out_outcome
);
  import htd_pkg::*;

  logic acc_short;
  logic acc_bit;

  assign acc_short = start && !busy &&
                     ((in_opcode == OP_WRITE) || (in_opcode == OP_RESTART));
  assign acc_bit   = start && !busy && (in_opcode == OP_BIT);

  `HTD_ASSERT_NOW(a_err_sym_zero, out_valid && (out_outcome == OUTCOME_ERR),
    out_symbol == '0, "error result carries a non-zero symbol")
  `HTD_ASSERT_NEXT(a_short_one_cycle, acc_short, !busy,
    "write or restart kept the unit busy")
  `HTD_ASSERT_NEXT(a_bit_no_early_result, acc_bit, !out_valid,
    "result one cycle after a bit was taken")
  `HTD_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid,
    "result strobe high for two cycles")
  `HTD_ASSERT_NOW(a_result_after_busy, out_valid, $past(busy),
    "result without a walk in progress")

endmodule

bind huffman_tree_decoder_unit htd_checker u_htd_checker (.*);
`default_nettype wire
